>>> hdl/cpd_pkg.sv
package cpd_pkg;

  localparam logic [3:0] PH_H0   = 4'd0;
  localparam logic [3:0] PH_H1   = 4'd1;
  localparam logic [3:0] PH_H2   = 4'd2;
  localparam logic [3:0] PH_M0   = 4'd3;
  localparam logic [3:0] PH_M1   = 4'd4;
  localparam logic [3:0] PH_N0   = 4'd5;
  localparam logic [3:0] PH_N1   = 4'd6;
  localparam logic [3:0] PH_L0   = 4'd7;
  localparam logic [3:0] PH_L1   = 4'd8;
  localparam logic [3:0] PH_PAY  = 4'd9;
  localparam logic [3:0] PH_C0   = 4'd10;
  localparam logic [3:0] PH_C1   = 4'd11;
  localparam logic [3:0] PH_DONE = 4'd12;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INCOMPLETE = 3'd1;
  localparam logic [2:0] ST_NUMBER     = 3'd2;
  localparam logic [2:0] ST_CHECKSUM   = 3'd3;
  localparam logic [2:0] ST_LENGTH     = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [7:0] CH_U    = 8'h55;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_F    = 8'h46;

  localparam logic [15:0] SUM_UF = 16'h009b;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [2:0]  code;
    logic [10:0] length;
    logic        last;
  } result_t;

endpackage

>>> hdl/cpd_parser.sv
module cpd_parser
  import cpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] expected_number,
  input  logic        window_end,
  output logic        res_valid,
  output result_t     res
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [16:0] LEN_LIMIT = 17'(MAX_PAYLOAD);

  logic [3:0]    phase, phase_next;
  logic [15:0]   declared_length, declared_length_next;
  logic [CW-1:0] bytes_counted, bytes_counted_next;
  logic [15:0]   running_sum, running_sum_next;
  logic [7:0]    received_check, received_check_next;

  logic [15:0]   sum_add;
  logic [15:0]   word;
  logic [CW-1:0] count_inc;
  logic          had_len;

  function automatic logic [10:0] shown_len(input logic [15:0] len);
    logic [16:0] sat;
    sat = ({1'b0, len} > LEN_LIMIT) ? LEN_LIMIT : {1'b0, len};
    return sat[10:0];
  endfunction

  always_comb begin
    phase_next           = phase;
    declared_length_next = declared_length;
    bytes_counted_next   = bytes_counted;
    running_sum_next     = running_sum;
    received_check_next  = received_check;
    res_valid            = 1'b0;
    res                  = '0;
    had_len              = 1'b0;

    sum_add   = running_sum + {8'h00, rx_byte};
    word      = {rx_byte, received_check};
    count_inc = bytes_counted + CW'(1);

    unique case (phase)
      PH_H0: phase_next = (rx_byte == CH_U) ? PH_H1 : PH_H0;
      PH_H1: begin
        if (rx_byte == CH_E) phase_next = PH_H2;
        else phase_next = (rx_byte == CH_U) ? PH_H1 : PH_H0;
      end
      PH_H2: begin
        if (rx_byte == CH_HASH) phase_next = PH_M0;
        else phase_next = (rx_byte == CH_U) ? PH_H1 : PH_H0;
      end
      PH_M0: phase_next = (rx_byte == CH_U) ? PH_M1 : PH_M0;
      PH_M1: begin
        if (rx_byte == CH_F) begin
          running_sum_next = SUM_UF;
          phase_next       = PH_N0;
        end else begin
          phase_next = (rx_byte == CH_U) ? PH_M1 : PH_M0;
        end
      end
      PH_N0: begin
        running_sum_next    = sum_add;
        received_check_next = rx_byte;
        phase_next          = PH_N1;
      end
      PH_N1: begin
        running_sum_next = sum_add;
        if (word != expected_number) begin
          res_valid  = 1'b1;
          res.kind   = KIND_STATUS;
          res.code   = ST_NUMBER;
          res.last   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_L0;
        end
      end
      PH_L0: begin
        running_sum_next    = sum_add;
        received_check_next = rx_byte;
        phase_next          = PH_L1;
      end
      PH_L1: begin
        running_sum_next     = sum_add;
        declared_length_next = word;
        bytes_counted_next   = '0;
        if ({1'b0, word} > LEN_LIMIT) begin
          res_valid  = 1'b1;
          res.kind   = KIND_STATUS;
          res.code   = ST_LENGTH;
          res.length = shown_len(word);
          res.last   = 1'b1;
          phase_next = PH_DONE;
        end else begin
          phase_next = (word == 16'h0000) ? PH_C0 : PH_PAY;
        end
      end
      PH_PAY: begin
        running_sum_next   = sum_add;
        bytes_counted_next = count_inc;
        if (17'(count_inc) >= {1'b0, declared_length}) phase_next = PH_C0;
        res_valid = 1'b1;
        res.kind  = KIND_PAYLOAD;
        res.data  = rx_byte;
      end
      PH_C0: begin
        received_check_next = rx_byte;
        phase_next          = PH_C1;
      end
      PH_C1: begin
        res_valid  = 1'b1;
        res.kind   = KIND_STATUS;
        res.code   = (word == running_sum) ? ST_OK : ST_CHECKSUM;
        res.length = shown_len(declared_length);
        res.last   = 1'b1;
        phase_next = PH_DONE;
      end
      default: phase_next = PH_DONE;
    endcase

    if (window_end) begin
      if (phase_next != PH_DONE) begin
        had_len = (phase_next == PH_PAY) || (phase_next == PH_C0) ||
                  (phase_next == PH_C1);
        res_valid  = 1'b1;
        res.kind   = KIND_STATUS;
        res.data   = 8'h00;
        res.code   = ST_INCOMPLETE;
        res.length = had_len ? shown_len(declared_length_next) : 11'd0;
        res.last   = 1'b1;
      end
      phase_next           = PH_H0;
      declared_length_next = '0;
      bytes_counted_next   = '0;
      running_sum_next     = '0;
      received_check_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_H0;
      declared_length <= '0;
      bytes_counted   <= '0;
      running_sum     <= '0;
      received_check  <= '0;
    end else if (take) begin
      phase           <= phase_next;
      declared_length <= declared_length_next;
      bytes_counted   <= bytes_counted_next;
      running_sum     <= running_sum_next;
      received_check  <= received_check_next;
    end
  end

endmodule

>>> hdl/camera_packet_deframer.sv
// A result is registered in the output register, or the skid register on stall.
// Throughput: one byte per cycle while the skid register is empty.
// An output register and a skid register hold up to two results under stall,
// so input is held off only while the skid register is occupied.
// Reset (rst, synchronous) rearms the parser to header search and empties both.
module camera_packet_deframer
  import cpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] expected_number,
  input  logic        window_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [7:0]  payload_byte,
  output logic [2:0]  status_code,
  output logic [10:0] payload_length,
  output logic        last_flag
);

  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_res;
  result_t skid_res;
  logic    skid_valid;
  logic    out_free;

  assign in_stall = skid_valid;
  assign take     = in_valid && !skid_valid;
  assign out_free = !out_valid || !out_stall;

  cpd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .rx_byte        (rx_byte),
    .expected_number(expected_number),
    .window_end     (window_end),
    .res_valid      (res_valid),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= take && res_valid;
      end
    end else if (take && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (!out_free && take && res_valid) begin
      skid_res <= res;
    end
  end

  assign result_kind    = out_res.kind;
  assign payload_byte   = out_res.data;
  assign status_code    = out_res.code;
  assign payload_length = out_res.length;
  assign last_flag      = out_res.last;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_last_marks_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_flag == result_kind))
    else $error("last flag disagrees with result kind");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == KIND_PAYLOAD) |->
      (status_code == ST_OK && payload_length == 11'd0))
    else $error("payload item carries status fields");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status_code <= ST_LENGTH))
    else $error("status code out of range");
`endif

endmodule
